// ===== hdl/rna_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational number ALU package
// Shared widths, codes and transaction types of the rational ALU.
// ----------------------------------------------------------------------------
package rna_pkg;

	// width of operand values
	localparam int VALUE_WIDTH = 32;
	// magnitude width of cross products
	localparam int DW = 2 * VALUE_WIDTH;

	typedef enum logic [2:0] {
		MODE_NORM = 3'd0,
		MODE_ADD  = 3'd1,
		MODE_SUB  = 3'd2,
		MODE_MUL  = 3'd3,
		MODE_DIV  = 3'd4,
		MODE_EQ   = 3'd5,
		MODE_LT   = 3'd6,
		MODE_NONE = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} operand_t;

	typedef struct packed {
		logic signed [31:0] result_num;
		logic [30:0]        result_den;
		logic               compare_true;
		logic [1:0]         status;
	} result_t;

	// work handed from front to back
	typedef struct packed {
		logic          direct;   // res is final, no reduction
		result_t       res;
		logic          neg;      // sign of numerator
		logic [DW-1:0] mag;      // numerator magnitude
		logic [DW-1:0] den;      // positive denominator
	} job_t;

endpackage

// ===== hdl/rna_queue.sv =====
// ----------------------------------------------------------------------------
// Rational ALU job queue
// Two-entry FIFO between the classify front and the reduce back.
// ----------------------------------------------------------------------------
module rna_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rna_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output rna_pkg::job_t  pop_job
);

	rna_pkg::job_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign pop_job  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (pop && nonempty) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && nonempty) ? 1 : 0);
		end
	end

endmodule

// ===== hdl/rna_front.sv =====
// ----------------------------------------------------------------------------
// Rational ALU front
// Accepts a transaction, flags special cases, forms cross products on one
// shared multiplier and hands an unreduced fraction or a final result to the queue.
// ----------------------------------------------------------------------------
module rna_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              operand_valid,
	output logic              operand_stall,
	input  rna_pkg::operand_t operand,
	output logic              push,
	output rna_pkg::job_t     push_job,
	input  logic              full
);

	localparam int W  = rna_pkg::VALUE_WIDTH;
	localparam int OW = W + 1;
	localparam int PW = 2 * OW;
	localparam int DW = rna_pkg::DW;

	typedef enum logic [2:0] {F_IDLE, F_M1, F_M2, F_M3, F_FORM, F_PUSH} fstate_t;

	fstate_t             state_q;
	logic signed [OW-1:0] an_q, ad_q, bn_q, bd_q;
	logic [2:0]           mode_q;
	logic signed [PW-1:0] p1_q, p2_q, p3_q;
	rna_pkg::job_t        job_q;

	// operand sign fix and classification
	logic signed [OW-1:0] an_c, ad_c, bn_c, bd_c;
	logic                 direct_c;
	logic [1:0]           dstat_c;
	rna_pkg::job_t        djob_c;
	always_comb begin
		an_c = OW'(signed'(operand.a_num[W-1:0]));
		ad_c = OW'(signed'(operand.a_den[W-1:0]));
		bn_c = OW'(signed'(operand.b_num[W-1:0]));
		bd_c = signed'(OW'(operand.b_den[W-2:0]));
		if (ad_c < 0) begin
			an_c = -an_c;
			ad_c = -ad_c;
		end
		direct_c = 1'b1;
		dstat_c  = rna_pkg::ST_OK;
		if (operand.mode == rna_pkg::MODE_NONE) begin
			dstat_c = rna_pkg::ST_OK;
		end else if (ad_c == 0 || (operand.mode != rna_pkg::MODE_NORM && bd_c == 0)) begin
			dstat_c = rna_pkg::ST_ZERO_DEN;
		end else if (operand.mode == rna_pkg::MODE_DIV && bn_c == 0) begin
			dstat_c = rna_pkg::ST_DIV_ZERO;
		end else begin
			direct_c = 1'b0;
		end
		// final 0/1 job for special cases
		djob_c                = '0;
		djob_c.direct         = 1'b1;
		djob_c.res.result_den = 31'd1;
		djob_c.res.status     = dstat_c;
	end

	// shared multiplier
	logic signed [OW-1:0] mx, my;
	logic signed [PW-1:0] prod;
	always_comb begin
		mx = an_q;
		my = bd_q;
		unique case (state_q)
			F_M1: begin
				mx = an_q;
				my = (mode_q == rna_pkg::MODE_MUL) ? bn_q : bd_q;
			end
			F_M2: begin
				mx = bn_q;
				my = ad_q;
			end
			F_M3: begin
				mx = ad_q;
				my = (mode_q == rna_pkg::MODE_DIV) ? bn_q : bd_q;
			end
			default: begin
				mx = an_q;
				my = bd_q;
			end
		endcase
		prod = mx * my;
	end

	// numerator and denominator assembly
	logic signed [PW-1:0] num_c, den_c, diff_c;
	rna_pkg::job_t        job_c;
	always_comb begin
		diff_c = p1_q - p2_q;
		num_c  = p1_q;
		den_c  = p3_q;
		unique case (mode_q)
			rna_pkg::MODE_NORM: begin
				num_c = PW'(an_q);
				den_c = PW'(ad_q);
			end
			rna_pkg::MODE_ADD: num_c = p1_q + p2_q;
			rna_pkg::MODE_SUB: num_c = diff_c;
			rna_pkg::MODE_DIV: begin
				if (p3_q < 0) begin
					num_c = -p1_q;
					den_c = -p3_q;
				end
			end
			default: num_c = p1_q;
		endcase
		job_c                  = '0;
		job_c.res.result_den   = 31'd1;
		job_c.res.status       = rna_pkg::ST_OK;
		job_c.neg              = num_c < 0;
		job_c.mag              = DW'((num_c < 0) ? -num_c : num_c);
		job_c.den              = DW'(den_c);
		if (mode_q == rna_pkg::MODE_EQ || mode_q == rna_pkg::MODE_LT) begin
			job_c.direct = 1'b1;
			job_c.res.compare_true = (mode_q == rna_pkg::MODE_EQ) ? (diff_c == 0) : (diff_c < 0);
		end
	end

	assign operand_stall = (state_q != F_IDLE);
	assign push          = (state_q == F_PUSH);
	assign push_job      = job_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (operand_valid) begin
						an_q   <= an_c;
						ad_q   <= ad_c;
						bn_q   <= bn_c;
						bd_q   <= bd_c;
						mode_q <= operand.mode;
						job_q  <= djob_c;
						if (direct_c) begin
							state_q <= F_PUSH;
						end else if (operand.mode == rna_pkg::MODE_NORM) begin
							state_q <= F_FORM;
						end else begin
							state_q <= F_M1;
						end
					end
				end
				F_M1: begin
					p1_q    <= prod;
					state_q <= F_M2;
				end
				F_M2: begin
					p2_q    <= prod;
					state_q <= F_M3;
				end
				F_M3: begin
					p3_q    <= prod;
					state_q <= F_FORM;
				end
				F_FORM: begin
					job_q   <= job_c;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/rna_back.sv =====
// ----------------------------------------------------------------------------
// Rational ALU back
// Reduces a fraction by binary gcd, divides both parts by the gcd with two
// restoring dividers, checks range and holds the result transaction.
// ----------------------------------------------------------------------------
module rna_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             nonempty,
	input  rna_pkg::job_t    pop_job,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output rna_pkg::result_t result
);

	localparam int W  = rna_pkg::VALUE_WIDTH;
	localparam int DW = rna_pkg::DW;
	localparam int CW = $clog2(DW);
	localparam logic [DW-1:0] LIM = DW'(1) << (W - 1);
	// zero over one, status ok
	localparam rna_pkg::result_t ZERO_RES = '{result_num: '0, result_den: 31'd1,
		compare_true: 1'b0, status: rna_pkg::ST_OK};

	typedef enum logic [2:0] {B_IDLE, B_GCD, B_DIV, B_FIN, B_OUT} bstate_t;

	bstate_t          state_q;
	logic [DW-1:0]    u_q, v_q, g_q;
	logic [CW-1:0]    k_q, cnt_q;
	logic             neg_q;
	logic [DW-1:0]    qn_q, qd_q, rn_q, rd_q;
	rna_pkg::result_t res_q;

	assign pop          = (state_q == B_IDLE) && nonempty;
	assign result_valid = (state_q == B_OUT);
	assign result       = res_q;

	// one restoring division step for each part
	logic [DW:0]   tn, td;
	logic [DW-1:0] nrn, nrd, nqn, nqd;
	always_comb begin
		tn  = {rn_q, qn_q[DW-1]};
		td  = {rd_q, qd_q[DW-1]};
		nrn = tn[DW-1:0];
		nqn = {qn_q[DW-2:0], 1'b0};
		if (tn >= {1'b0, g_q}) begin
			nrn = DW'(tn - {1'b0, g_q});
			nqn[0] = 1'b1;
		end
		nrd = td[DW-1:0];
		nqd = {qd_q[DW-2:0], 1'b0};
		if (td >= {1'b0, g_q}) begin
			nrd = DW'(td - {1'b0, g_q});
			nqd[0] = 1'b1;
		end
	end

	// range check and sign restore
	logic [DW-1:0]    nv;
	rna_pkg::result_t fin_c;
	always_comb begin
		nv    = neg_q ? -qn_q : qn_q;
		fin_c = '0;
		if ((neg_q ? (qn_q > LIM) : (qn_q > LIM - DW'(1))) || qd_q > LIM - DW'(1)) begin
			fin_c.result_den = 31'd1;
			fin_c.status     = rna_pkg::ST_OVERFLOW;
		end else begin
			fin_c.result_num = 32'(signed'(nv[W-1:0]));
			fin_c.result_den = 31'(qd_q[W-2:0]);
			fin_c.status     = rna_pkg::ST_OK;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (nonempty) begin
						neg_q <= pop_job.neg;
						qn_q  <= pop_job.mag;
						qd_q  <= pop_job.den;
						u_q   <= pop_job.mag;
						v_q   <= pop_job.den;
						k_q   <= '0;
						if (pop_job.direct) begin
							res_q   <= pop_job.res;
							state_q <= B_OUT;
						end else if (pop_job.mag == '0) begin
							res_q   <= ZERO_RES;
							state_q <= B_OUT;
						end else begin
							state_q <= B_GCD;
						end
					end
				end
				B_GCD: begin
					priority if (u_q == '0 || v_q == '0) begin
						g_q     <= (u_q | v_q) << k_q;
						rn_q    <= '0;
						rd_q    <= '0;
						cnt_q   <= '0;
						state_q <= B_DIV;
					end else if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + CW'(1);
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (u_q >= v_q) begin
						u_q <= (u_q - v_q) >> 1;
					end else begin
						v_q <= (v_q - u_q) >> 1;
					end
				end
				B_DIV: begin
					rn_q  <= nrn;
					rd_q  <= nrd;
					qn_q  <= nqn;
					qd_q  <= nqd;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DW - 1)) state_q <= B_FIN;
				end
				B_FIN: begin
					res_q   <= fin_c;
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (!result_stall) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/rational_number_alu_top.sv =====
// ----------------------------------------------------------------------------
// Rational number ALU
// Normalize, add, subtract, multiply, divide and compare fractions with
// gcd reduction and range checking.
// ----------------------------------------------------------------------------
// channel   direction  handshake                      payload
// operand   input      operand_valid / operand_stall  rna_pkg::operand_t
// result    output     result_valid / result_stall    rna_pkg::result_t
//
// Front: special cases skip straight to the push, normalize skips the products,
// and the other modes take the three products in turn on one 33x33 multiplier.
// Back: binary gcd by steps of one 64-bit subtract or shift, then 64 division
// steps and one range check; special cases skip the gcd and the division.
// A two-entry queue lets the front take the next transaction while the back
// reduces. Reset clears all control state; a stalled result holds.
module rational_number_alu_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              operand_valid,
	output logic              operand_stall,
	input  rna_pkg::operand_t operand,
	output logic              result_valid,
	input  logic              result_stall,
	output rna_pkg::result_t  result
);

	logic          push, full, pop, nonempty;
	rna_pkg::job_t push_job, pop_job;

	rna_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.operand_stall (operand_stall),
		.operand       (operand),
		.push          (push),
		.push_job      (push_job),
		.full          (full)
	);

	rna_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.pop_job  (pop_job)
	);

	rna_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.nonempty     (nonempty),
		.pop_job      (pop_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// error results carry zero over one
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != rna_pkg::ST_OK |->
		result.result_num == 0 && result.result_den == 31'd1 && !result.compare_true)
		else $error("error result not 0/1");

	// a delivered denominator is never zero
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.result_den != 31'd0)
		else $error("zero result denominator");

	// a true comparison has a clean 0/1 payload
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.compare_true |->
		result.status == rna_pkg::ST_OK && result.result_num == 0)
		else $error("bad comparison result");

endmodule
